[sv/ecr_pkg.sv]
// Shared types, codes and defaults for the EDCA internal collision resolver.
package ecr_pkg;

  // Default sizing of the slot table.
  localparam int NUM_SLOTS_DEF = 4;
  localparam int TIME_BITS_DEF = 48;

  // Fixed widths of the transaction fields.
  localparam int FUNC_W     = 2;
  localparam int SLOT_IDX_W = 2;
  localparam int TIME_W     = 48;
  localparam int MASK_W     = 4;
  localparam int STATUS_W   = 2;

  // Request function codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_SCHEDULE = 2'd0,
    FN_CANCEL   = 2'd1,
    FN_FIRE     = 2'd2
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_SLOT  = 2'd1,
    STAT_ALREADY   = 2'd2,
    STAT_TOO_EARLY = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_SCAN,
    S_DONE
  } state_t;

  // Request transaction payload.
  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [TIME_W-1:0]     time_value;
  } req_t;

  // Result transaction payload.
  typedef struct packed {
    logic [MASK_W-1:0]   granted_mask;
    logic [MASK_W-1:0]   collision_mask;
    logic [TIME_W-1:0]   next_time;
    logic                next_valid;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
    logic scan_init;
    logic scan_step;
    logic out_load;
  } ecr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } ecr_sts_t;

endpackage

[sv/ecr_stream_if.sv]
// Valid/ready stream interface that carries one payload per transaction.
interface ecr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/ecr_ctrl.sv]
// Controller state machine that sequences capture, update, slot scan and result load.
module ecr_ctrl
  import ecr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ecr_sts_t sts,
  output ecr_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_APPLY: begin
        cmd.apply     = 1'b1;
        cmd.scan_init = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !sts.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[sv/ecr_dpath.sv]
// Datapath with the slot table, request checks, slot scan and the result register.
module ecr_dpath
  import ecr_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  ecr_cmd_t cmd,
  output ecr_sts_t sts,
  input  req_t     in_data,
  input  logic     out_ready,
  output logic     out_valid,
  output rsp_t     out_data
);

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDX_W   = (SLOT_W > SLOT_IDX_W) ? SLOT_W : SLOT_IDX_W;
  localparam int WIDE_T  = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
  localparam int WIDE_M  = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;
  localparam int CNT_W   = 5;

  // Captured request.
  logic [FUNC_W-1:0]     req_func;
  logic [SLOT_IDX_W-1:0] req_slot;
  logic [TIME_BITS-1:0]  req_time;

  // Slot table and fire history.
  logic [TIME_BITS-1:0] slot_time [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_pending;
  logic [TIME_BITS-1:0] last_fire;

  // Scan state.
  logic [SLOT_W-1:0]    scan_idx;
  logic [NUM_SLOTS-1:0] grant_mask;
  logic [NUM_SLOTS-1:0] coll_mask;
  logic [TIME_BITS-1:0] min_time;
  logic                 min_valid;
  status_t              status;

  // Derived request values.
  logic [WIDE_T-1:0]    in_time_wide;
  logic [IDX_W-1:0]     slot_wide;
  logic [SLOT_W-1:0]    slot_addr;
  logic                 slot_ok;

  // Scan element.
  logic [TIME_BITS-1:0] cur_time;
  logic                 cur_pend;
  logic                 cur_hit;

  // Result formatting.
  logic [WIDE_T-1:0]    min_wide;
  logic [WIDE_M-1:0]    grant_wide;
  logic [WIDE_M-1:0]    coll_wide;

  assign in_time_wide = WIDE_T'(in_data.time_value);
  assign slot_wide    = IDX_W'(req_slot);
  assign slot_addr    = slot_wide[SLOT_W-1:0];
  assign slot_ok      = (CNT_W'(req_slot) < CNT_W'(NUM_SLOTS));

  assign cur_time = slot_time[scan_idx];
  assign cur_pend = slot_pending[scan_idx];
  assign cur_hit  = (req_func == FN_FIRE) && cur_pend && (cur_time == req_time);

  assign sts.scan_last = (scan_idx == '0);
  assign sts.out_busy  = out_valid && !out_ready;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func <= in_data.func;
      req_slot <= in_data.slot_index;
      req_time <= in_time_wide[TIME_BITS-1:0];
    end
  end

  // Slot start times; only written by an accepted schedule.
  always_ff @(posedge clk) begin
    if (cmd.apply && (req_func == FN_SCHEDULE) && slot_ok && !slot_pending[slot_addr] &&
        (req_time > last_fire)) begin
      slot_time[slot_addr] <= req_time;
    end
  end

  // Pending flags, fire history and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_pending <= '0;
      last_fire    <= '0;
      status       <= STAT_OK;
    end else if (cmd.apply) begin
      case (req_func)
        FN_SCHEDULE: begin
          if (!slot_ok) begin
            status <= STAT_BAD_SLOT;
          end else if (slot_pending[slot_addr]) begin
            status <= STAT_ALREADY;
          end else if (req_time <= last_fire) begin
            status <= STAT_TOO_EARLY;
          end else begin
            slot_pending[slot_addr] <= 1'b1;
            status                  <= STAT_OK;
          end
        end
        FN_CANCEL: begin
          if (!slot_ok) begin
            status <= STAT_BAD_SLOT;
          end else begin
            slot_pending[slot_addr] <= 1'b0;
            status                  <= STAT_OK;
          end
        end
        FN_FIRE: begin
          last_fire <= req_time;
          status    <= STAT_OK;
        end
        default: begin
          status <= STAT_OK;
        end
      endcase
    end else if (cmd.scan_step && cur_hit) begin
      slot_pending[scan_idx] <= 1'b0;
    end
  end

  // Scan from the highest slot down: grant, collisions and earliest remaining time.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx   <= SLOT_W'(NUM_SLOTS - 1);
      grant_mask <= '0;
      coll_mask  <= '0;
      min_time   <= '0;
      min_valid  <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx - 1'b1;
      if (cur_hit) begin
        if (grant_mask == '0) begin
          grant_mask[scan_idx] <= 1'b1;
        end else begin
          coll_mask[scan_idx] <= 1'b1;
        end
      end else if (cur_pend && (!min_valid || (cur_time < min_time))) begin
        min_time  <= cur_time;
        min_valid <= 1'b1;
      end
    end
  end

  assign min_wide   = WIDE_T'(min_time);
  assign grant_wide = WIDE_M'(grant_mask);
  assign coll_wide  = WIDE_M'(coll_mask);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.granted_mask   <= grant_wide[MASK_W-1:0];
      out_data.collision_mask <= coll_wide[MASK_W-1:0];
      out_data.next_time      <= min_wide[TIME_W-1:0];
      out_data.next_valid     <= min_valid;
      out_data.status         <= STATUS_W'(status);
    end
  end

endmodule

[sv/edca_internal_collision_resolver.sv]
// A request is captured in S_IDLE, applied to the slot table in S_APPLY, scanned in S_SCAN
// and its result loaded in S_DONE once the output register is free; the scan walks the
// slot table one slot per cycle for grants, collisions and the earliest pending time.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears all pending flags, the last fire time and
// the output valid; slot start times are not cleared.
module edca_internal_collision_resolver
  import ecr_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  ecr_stream_if.sink          req,
  ecr_stream_if.source        rsp
);

  ecr_cmd_t cmd;
  ecr_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  rsp_t     out_data;
  req_t     in_data;

  assign in_data   = req.data;
  assign req.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Sequencing.
  ecr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot table and result path.
  ecr_dpath #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (rsp.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
